// File: hw/rtl/pbpm_pkg.sv
// ----------------------------------------------------------------------------
// pbpm_pkg
// shared constants and types of the page buffer pool manager
// ----------------------------------------------------------------------------
`default_nettype none
package pbpm_pkg;
  localparam int unsigned POOL_FRAMES  = 16;
  localparam int unsigned PAGE_ID_BITS = 32;
  localparam int unsigned PIN_BITS     = 16;
  localparam int unsigned IDX_BITS     = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int unsigned CNT_BITS     = $clog2(POOL_FRAMES + 1);
  localparam int unsigned CMD_BITS     = 3;
  localparam int unsigned STS_BITS     = 3;
  localparam int unsigned IN_FLD_BITS  = 2 * PAGE_ID_BITS + 1;
  localparam int unsigned IN_DATA_BITS = ((IN_FLD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FLD_BITS = IDX_BITS + PAGE_ID_BITS + 3;
  localparam int unsigned OUT_DATA_BITS = ((OUT_FLD_BITS + 7) / 8) * 8;
  localparam int unsigned IN_USER_BITS  = 8;
  localparam int unsigned OUT_USER_BITS = 8;

  localparam logic [CMD_BITS-1:0] CMD_FETCH  = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_NEW    = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_UNPIN  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_FLUSH  = 3'd4;

  localparam logic [STS_BITS-1:0] STS_OK        = 3'd0;
  localparam logic [STS_BITS-1:0] STS_NO_FRAME  = 3'd1;
  localparam logic [STS_BITS-1:0] STS_NOT_RES   = 3'd2;
  localparam logic [STS_BITS-1:0] STS_PINNED    = 3'd3;
  localparam logic [STS_BITS-1:0] STS_PIN_ZERO  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VREAD,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic                remove;
    logic [IDX_BITS-1:0] remove_idx;
    logic                push;
    logic [IDX_BITS-1:0] push_idx;
  } lru_op_t;
endpackage
`default_nettype wire

// File: hw/rtl/pbpm_ram.sv
// ----------------------------------------------------------------------------
// pbpm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module pbpm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end
endmodule
`default_nettype wire

// File: hw/rtl/pbpm_lru.sv
// ----------------------------------------------------------------------------
// pbpm_lru
// lru order of unpinned frames kept as a rank per frame
// ----------------------------------------------------------------------------
`default_nettype none
module pbpm_lru (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pbpm_pkg::lru_op_t                 op_i,
  output logic [pbpm_pkg::POOL_FRAMES-1:0]       in_lru_o,
  output logic [pbpm_pkg::IDX_BITS-1:0]          rank_o [pbpm_pkg::POOL_FRAMES],
  output logic [pbpm_pkg::CNT_BITS-1:0]          count_o
);
  import pbpm_pkg::*;

  logic [POOL_FRAMES-1:0] in_lru_q;
  logic [IDX_BITS-1:0]    rank_q [POOL_FRAMES];
  logic [CNT_BITS-1:0]    count_q;
  logic                   rm_hit;
  logic [IDX_BITS-1:0]    rm_rank;

  assign rm_hit  = op_i.remove && in_lru_q[op_i.remove_idx];
  assign rm_rank = rank_q[op_i.remove_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_lru_q <= '0;
      count_q  <= '0;
      for (int i = 0; i < POOL_FRAMES; i++) rank_q[i] <= '0;
    end else if (rm_hit) begin
      for (int i = 0; i < POOL_FRAMES; i++) begin
        if (in_lru_q[i] && rank_q[i] > rm_rank) rank_q[i] <= rank_q[i] - 1'b1;
      end
      in_lru_q[op_i.remove_idx] <= 1'b0;
      count_q <= count_q - 1'b1;
    end else if (op_i.push && !in_lru_q[op_i.push_idx] && count_q < CNT_BITS'(POOL_FRAMES)) begin
      in_lru_q[op_i.push_idx] <= 1'b1;
      rank_q[op_i.push_idx]   <= count_q[IDX_BITS-1:0];
      count_q <= count_q + 1'b1;
    end
  end

  assign in_lru_o = in_lru_q;
  assign rank_o   = rank_q;
  assign count_o  = count_q;
endmodule
`default_nettype wire

// File: hw/rtl/page_buffer_pool_manager.sv
// ----------------------------------------------------------------------------
// page_buffer_pool_manager
// maps page ids to a pool of frames with a fifo free list and lru eviction
// ----------------------------------------------------------------------------
// channel   dir  tuser          tdata
// s_axis    in   command        page_id, allocated_page, mark_dirty
// m_axis    out  status         frame_index, write_back, write_back_page,
//                               read_in, release_page
//
// a request runs from accept to result through a read priming step, one
// compare per frame against the page id ram, a victim page read and an
// update step; the next request is accepted in the cycle after the update,
// so a new request is not taken while one is still in progress
// reset empties the pool at once, no clearing pass
// a result waits in the output register; the update cycle stalls until free
// ----------------------------------------------------------------------------
`default_nettype none
module page_buffer_pool_manager (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // page_id, allocated_page, mark_dirty
  input  wire logic [pbpm_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // command
  input  wire logic [pbpm_pkg::IN_USER_BITS-1:0]   s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // frame_index, write_back, write_back_page, read_in, release_page
  output logic [pbpm_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata,
  // status
  output logic [pbpm_pkg::OUT_USER_BITS-1:0]       m_axis_tuser
);
  import pbpm_pkg::*;

  state_e state_q, state_d;

  logic [CMD_BITS-1:0]     cmd_q;
  logic [PAGE_ID_BITS-1:0] tgt_q;
  logic                    dirty_q;
  logic [CNT_BITS-1:0]     cnt_q;
  logic                    hit_q;
  logic [IDX_BITS-1:0]     hit_idx_q;
  logic                    vic_ok_q;
  logic [IDX_BITS-1:0]     vic_idx_q;

  logic [POOL_FRAMES-1:0]  valid_q;
  logic [POOL_FRAMES-1:0]  fdirty_q;
  logic [PIN_BITS-1:0]     pins_q [POOL_FRAMES];
  logic [IDX_BITS-1:0]     fq_q [POOL_FRAMES];
  logic [IDX_BITS-1:0]     fq_head_q;
  logic [CNT_BITS-1:0]     free_cnt_q;

  logic [POOL_FRAMES-1:0]  in_lru;
  logic [IDX_BITS-1:0]     rank [POOL_FRAMES];
  logic [CNT_BITS-1:0]     lru_cnt;
  lru_op_t                 lru_op;

  logic                    ram_we;
  logic [IDX_BITS-1:0]     ram_waddr, ram_raddr, scan_idx;
  logic [PAGE_ID_BITS-1:0] ram_rdata;

  logic                    commit;
  logic [STS_BITS-1:0]     sts;
  logic [IDX_BITS-1:0]     fidx;
  logic                    wb, rd, rel;
  logic [PAGE_ID_BITS-1:0] wb_page;
  logic                    take_free, alloc;
  logic [IDX_BITS-1:0]     alloc_idx;
  logic [CNT_BITS:0]       tail_sum;
  logic [IDX_BITS-1:0]     fq_tail;
  logic [PIN_BITS-1:0]     hit_pins;
  logic                    out_valid_q;
  logic [STS_BITS-1:0]     out_sts_q;
  logic [IDX_BITS-1:0]     out_fidx_q;
  logic                    out_wb_q, out_rd_q, out_rel_q;
  logic [PAGE_ID_BITS-1:0] out_wbp_q;

  pbpm_ram #(.WIDTH(PAGE_ID_BITS), .DEPTH(POOL_FRAMES)) u_page_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (tgt_q),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  pbpm_lru u_lru (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (lru_op),
    .in_lru_o (in_lru),
    .rank_o   (rank),
    .count_o  (lru_cnt)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign scan_idx      = IDX_BITS'(cnt_q - 1'b1);
  assign ram_raddr     = (state_q == ST_VREAD || state_q == ST_EXEC) ? vic_idx_q :
                         cnt_q[IDX_BITS-1:0];
  assign commit        = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
  assign hit_pins      = pins_q[hit_idx_q];
  assign tail_sum      = {1'b0, fq_head_q} + {1'b0, free_cnt_q};
  assign fq_tail       = (tail_sum >= (CNT_BITS + 1)'(POOL_FRAMES)) ?
                         IDX_BITS'(tail_sum - (CNT_BITS + 1)'(POOL_FRAMES)) :
                         IDX_BITS'(tail_sum);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_SCAN;
      ST_SCAN:  if (cnt_q == CNT_BITS'(POOL_FRAMES)) state_d = ST_VREAD;
      ST_VREAD: state_d = ST_EXEC;
      ST_EXEC:  if (commit) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // request decision
  always_comb begin
    sts = STS_OK; fidx = '0; wb = 1'b0; wb_page = '0; rd = 1'b0; rel = 1'b0;
    take_free = 1'b0; alloc = 1'b0; alloc_idx = '0;
    lru_op = '0;
    case (cmd_q)
      CMD_FETCH, CMD_NEW: begin
        if (hit_q) begin
          fidx = hit_idx_q;
          lru_op.remove = commit;
          lru_op.remove_idx = hit_idx_q;
        end else if (free_cnt_q != '0) begin
          take_free = 1'b1; alloc = 1'b1; alloc_idx = fq_q[fq_head_q];
        end else if (lru_cnt != '0 && vic_ok_q) begin
          alloc = 1'b1; alloc_idx = vic_idx_q;
          lru_op.remove = commit;
          lru_op.remove_idx = vic_idx_q;
          if (fdirty_q[vic_idx_q]) begin
            wb = 1'b1; wb_page = ram_rdata;
          end
        end else begin
          sts = STS_NO_FRAME;
        end
        if (alloc) begin
          fidx = alloc_idx;
          rd = (cmd_q == CMD_FETCH);
        end
      end
      CMD_DELETE: begin
        if (hit_q) begin
          if (hit_pins != '0) begin
            sts = STS_PINNED;
          end else begin
            fidx = hit_idx_q; rel = 1'b1;
            lru_op.remove = commit;
            lru_op.remove_idx = hit_idx_q;
          end
        end
      end
      CMD_UNPIN: begin
        if (!hit_q) sts = STS_NOT_RES;
        else if (hit_pins == '0) sts = STS_PIN_ZERO;
        else begin
          fidx = hit_idx_q;
          lru_op.push = commit && (hit_pins == PIN_BITS'(1));
          lru_op.push_idx = hit_idx_q;
        end
      end
      CMD_FLUSH: begin
        if (!hit_q) sts = STS_NOT_RES;
        else begin
          fidx = hit_idx_q; wb = 1'b1; wb_page = tgt_q;
        end
      end
      default: ;
    endcase
    ram_we    = commit && alloc;
    ram_waddr = alloc_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      vic_ok_q    <= 1'b0;
      vic_idx_q   <= '0;
      valid_q     <= '0;
      fdirty_q    <= '0;
      fq_head_q   <= '0;
      free_cnt_q  <= CNT_BITS'(POOL_FRAMES);
      out_valid_q <= 1'b0;
      for (int i = 0; i < POOL_FRAMES; i++) begin
        pins_q[i] <= '0;
        fq_q[i]   <= IDX_BITS'(i);
      end
    end else begin
      state_q <= state_d;
      if (commit) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          cnt_q    <= '0;
          hit_q    <= 1'b0;
          vic_ok_q <= 1'b0;
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q != '0) begin
            if (!hit_q && valid_q[scan_idx] && ram_rdata == tgt_q) begin
              hit_q <= 1'b1; hit_idx_q <= scan_idx;
            end
            if (in_lru[scan_idx] && rank[scan_idx] == '0) begin
              vic_ok_q <= 1'b1; vic_idx_q <= scan_idx;
            end
          end
        end
        ST_EXEC: begin
          if (commit) begin
            if (alloc) begin
              valid_q[alloc_idx]  <= 1'b1;
              fdirty_q[alloc_idx] <= 1'b0;
              pins_q[alloc_idx]   <= PIN_BITS'(1);
            end
            if (take_free) begin
              free_cnt_q <= free_cnt_q - 1'b1;
              fq_head_q  <= (fq_head_q == IDX_BITS'(POOL_FRAMES - 1)) ? '0 : fq_head_q + 1'b1;
            end
            if ((cmd_q == CMD_FETCH || cmd_q == CMD_NEW) && hit_q && hit_pins != '1) begin
              pins_q[hit_idx_q] <= hit_pins + 1'b1;
            end
            if (rel) begin
              valid_q[hit_idx_q]  <= 1'b0;
              fdirty_q[hit_idx_q] <= 1'b0;
              if (free_cnt_q < CNT_BITS'(POOL_FRAMES)) begin
                fq_q[fq_tail] <= hit_idx_q;
                free_cnt_q    <= free_cnt_q + 1'b1;
              end
            end
            if (cmd_q == CMD_UNPIN && sts == STS_OK) begin
              pins_q[hit_idx_q] <= hit_pins - 1'b1;
              if (dirty_q) fdirty_q[hit_idx_q] <= 1'b1;
            end
            if (cmd_q == CMD_FLUSH && sts == STS_OK) fdirty_q[hit_idx_q] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      cmd_q   <= s_axis_tuser[CMD_BITS-1:0];
      tgt_q   <= (s_axis_tuser[CMD_BITS-1:0] == CMD_NEW) ?
                 s_axis_tdata[2*PAGE_ID_BITS-1:PAGE_ID_BITS] : s_axis_tdata[PAGE_ID_BITS-1:0];
      dirty_q <= s_axis_tdata[2*PAGE_ID_BITS];
    end
    if (commit) begin
      out_sts_q  <= sts;
      out_fidx_q <= fidx;
      out_wb_q   <= wb;
      out_wbp_q  <= wb_page;
      out_rd_q   <= rd;
      out_rel_q  <= rel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = OUT_USER_BITS'(out_sts_q);
  assign m_axis_tdata  = OUT_DATA_BITS'({out_rel_q, out_rd_q, out_wbp_q, out_wb_q, out_fidx_q});
endmodule
`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the page buffer pool manager: random and directed
// requests, a behavioral pool model predicts every result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import pbpm_pkg::*;

  localparam int NF = POOL_FRAMES;
  localparam logic [PIN_BITS-1:0] PIN_FULL = '1;

  typedef struct packed {
    logic [CMD_BITS-1:0]     cmd;
    logic [PAGE_ID_BITS-1:0] pid;
    logic [PAGE_ID_BITS-1:0] apid;
    logic                    dirty;
  } req_t;

  typedef struct packed {
    logic [STS_BITS-1:0]     status;
    logic [IDX_BITS-1:0]     fidx;
    logic                    wb;
    logic [PAGE_ID_BITS-1:0] wb_page;
    logic                    rd;
    logic                    rel;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
  logic [IN_USER_BITS-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic [OUT_USER_BITS-1:0] m_axis_tuser;

  page_buffer_pool_manager uut (.*);

  always #6 clk_i = ~clk_i;

  // pool model
  logic                    pv [NF];
  logic [PAGE_ID_BITS-1:0] pp [NF];
  logic [PIN_BITS-1:0]     pn [NF];
  logic                    pd [NF];
  int free_q[$];
  int lru_q[$];

  req_t pending_q[$];
  rsp_t expected_q[$];
  int   errors = 0;
  int   sent = 0;
  int   got = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;
  bit   hold = 1'b0;
  bit   done = 1'b0;
  bit   in_taken = 1'b0;

  function automatic int lookup(logic [PAGE_ID_BITS-1:0] p);
    for (int i = 0; i < NF; i++) if (pv[i] && pp[i] == p) return i;
    return -1;
  endfunction

  function automatic void lru_drop(int f);
    for (int i = lru_q.size() - 1; i >= 0; i--) if (lru_q[i] == f) lru_q.delete(i);
  endfunction

  function automatic void enqueue(req_t x);
    pending_q = {pending_q, x};
  endfunction

  function automatic rsp_t pool_apply(req_t r);
    rsp_t o;
    int f;
    logic [PAGE_ID_BITS-1:0] tgt;
    o = '0;
    case (r.cmd)
      CMD_FETCH, CMD_NEW: begin
        tgt = (r.cmd == CMD_FETCH) ? r.pid : r.apid;
        f = lookup(tgt);
        if (f >= 0) begin
          if (pn[f] != PIN_FULL) pn[f]++;
          lru_drop(f);
          o.fidx = IDX_BITS'(f);
        end else begin
          if (free_q.size() > 0) begin
            f = free_q[0];
            free_q.delete(0);
          end else if (lru_q.size() > 0) begin
            f = lru_q[0];
            lru_q.delete(0);
            if (pv[f] && pd[f]) begin
              o.wb = 1'b1;
              o.wb_page = pp[f];
            end
          end
          if (f < 0) o.status = STS_NO_FRAME;
          else begin
            pv[f] = 1'b1; pp[f] = tgt; pn[f] = PIN_BITS'(1); pd[f] = 1'b0;
            o.fidx = IDX_BITS'(f);
            o.rd = (r.cmd == CMD_FETCH);
          end
        end
      end
      CMD_DELETE: begin
        f = lookup(r.pid);
        if (f >= 0) begin
          if (pn[f] != '0) o.status = STS_PINNED;
          else begin
            pv[f] = 1'b0; pd[f] = 1'b0;
            lru_drop(f);
            free_q = {free_q, f};
            o.fidx = IDX_BITS'(f);
            o.rel = 1'b1;
          end
        end
      end
      CMD_UNPIN: begin
        f = lookup(r.pid);
        if (f < 0) o.status = STS_NOT_RES;
        else if (pn[f] == '0) o.status = STS_PIN_ZERO;
        else begin
          if (r.dirty) pd[f] = 1'b1;
          pn[f]--;
          if (pn[f] == '0) begin
            lru_drop(f);
            lru_q = {lru_q, f};
          end
          o.fidx = IDX_BITS'(f);
        end
      end
      CMD_FLUSH: begin
        f = lookup(r.pid);
        if (f < 0) o.status = STS_NOT_RES;
        else begin
          o.wb = 1'b1; o.wb_page = r.pid; pd[f] = 1'b0; o.fidx = IDX_BITS'(f);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (pending_q.size() > 0 && !hold && (quiet || $urandom_range(99) >= 23)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= IN_USER_BITS'(pending_q[0].cmd);
          s_axis_tdata  <= IN_DATA_BITS'({pending_q[0].dirty, pending_q[0].apid,
                                          pending_q[0].pid});
          pending_q.delete(0);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= quiet || ($urandom_range(99) >= 23);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t act;
    req_t r;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        r.pid   = s_axis_tdata[PAGE_ID_BITS-1:0];
        r.apid  = s_axis_tdata[2*PAGE_ID_BITS-1:PAGE_ID_BITS];
        r.dirty = s_axis_tdata[2*PAGE_ID_BITS];
        r.cmd   = s_axis_tuser[CMD_BITS-1:0];
        expected_q = {expected_q, pool_apply(r)};
        sent <= sent + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act.status  = m_axis_tuser[STS_BITS-1:0];
        act.fidx    = m_axis_tdata[IDX_BITS-1:0];
        act.wb      = m_axis_tdata[IDX_BITS];
        act.wb_page = m_axis_tdata[IDX_BITS+1 +: PAGE_ID_BITS];
        act.rd      = m_axis_tdata[IDX_BITS+1+PAGE_ID_BITS];
        act.rel     = m_axis_tdata[IDX_BITS+2+PAGE_ID_BITS];
        got <= got + 1;
        if (expected_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected result %p", act);
        end else begin
          if (act !== expected_q[0]) begin
            errors = errors + 1;
            if (errors <= 10) $display("mismatch exp %p act %p", expected_q[0], act);
          end
          expected_q.delete(0);
        end
      end
      if (cycles > 600000 && !done) begin
        $display("timeout after %0d cycles", cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic req_t mk(logic [2:0] c, logic [PAGE_ID_BITS-1:0] p,
                              logic [PAGE_ID_BITS-1:0] a, int d);
    req_t r;
    r.cmd = c; r.pid = p; r.apid = a; r.dirty = d[0];
    return r;
  endfunction

  function automatic logic [PAGE_ID_BITS-1:0] pick_page();
    if ($urandom_range(9) == 0) return $urandom();
    if ($urandom_range(19) == 0) return ~$urandom_range(3);
    return 32'h100 + $urandom_range(23);
  endfunction

  initial begin
    req_t r;
    logic [PAGE_ID_BITS-1:0] p;
    for (int i = 0; i < NF; i++) begin
      pv[i] = 1'b0; pp[i] = '0; pn[i] = '0; pd[i] = 1'b0; free_q = {free_q, i};
    end
    // directed: extremes, every command, error paths
    enqueue(mk(CMD_UNPIN, 32'h0, 32'h0, 1));
    enqueue(mk(CMD_FLUSH, 32'hFFFF_FFFF, 32'h0, 0));
    enqueue(mk(CMD_DELETE, 32'h5, 32'h0, 0));
    enqueue(mk(CMD_FETCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    enqueue(mk(CMD_NEW, 32'h0, 32'h0, 0));
    enqueue(mk(CMD_NEW, 32'h0, 32'hFFFF_FFFF, 0));
    enqueue(mk(CMD_DELETE, 32'hFFFF_FFFF, 32'h0, 0));
    enqueue(mk(CMD_UNPIN, 32'hFFFF_FFFF, 32'h0, 1));
    enqueue(mk(CMD_UNPIN, 32'hFFFF_FFFF, 32'h0, 0));
    enqueue(mk(CMD_UNPIN, 32'hFFFF_FFFF, 32'h0, 1));
    enqueue(mk(CMD_FLUSH, 32'hFFFF_FFFF, 32'h0, 0));
    enqueue(mk(CMD_DELETE, 32'hFFFF_FFFF, 32'h0, 0));
    enqueue(mk(3'd5, 32'hAAAA_5555, 32'h5555_AAAA, 1));
    enqueue(mk(3'd7, 32'h0, 32'hFFFF_FFFF, 0));
    for (int i = 0; i < 10; i++) enqueue(mk(CMD_FETCH, 32'h200 + i, 0, 0));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && expected_q.size() == 0 && !s_axis_tvalid);
    // fill the pool, then ask three more times with nothing free
    for (int i = 0; i < 7; i++) enqueue(mk(CMD_NEW, 0, 32'h300 + i, 0));
    enqueue(mk(CMD_FETCH, 32'h400, 0, 0));
    // dirty unpin then eviction with write back
    enqueue(mk(CMD_UNPIN, 32'h200, 0, 1));
    enqueue(mk(CMD_FETCH, 32'h401, 0, 0));
    // random part: mostly fetch and unpin requests on a small page set
    for (int n = 0; n < 1950; n++) begin
      p = pick_page();
      case ($urandom_range(9))
        0, 1, 2: r = mk(CMD_FETCH, p, $urandom(), $urandom_range(1));
        3:       r = mk(CMD_NEW, $urandom(), pick_page(), $urandom_range(1));
        4:       r = mk(CMD_DELETE, p, $urandom(), $urandom_range(1));
        5, 6, 7: r = mk(CMD_UNPIN, p, $urandom(), $urandom_range(1));
        8:       r = mk(CMD_FLUSH, p, $urandom(), $urandom_range(1));
        default: r = mk(3'($urandom_range(7)), p, $urandom(), $urandom_range(1));
      endcase
      enqueue(r);
      if (n == 700) begin
        wait (pending_q.size() == 0);
        hold = 1'b1;
        wait (!s_axis_tvalid && expected_q.size() == 0);
        hold = 1'b0;
        quiet = 1'b1;
      end
      if (n == 1100) begin
        wait (pending_q.size() == 0);
        quiet = 1'b0;
      end
      // pin one page four times, then unpin it four times
      if (n == 1500) begin
        for (int k = 0; k < 4; k++) enqueue(mk(CMD_FETCH, 32'h777, 0, 0));
        for (int k = 0; k < 4; k++) enqueue(mk(CMD_UNPIN, 32'h777, 0, 1));
      end
    end
    wait (pending_q.size() == 0 && !s_axis_tvalid);
    wait (expected_q.size() == 0);
    repeat (4 * NF) @(posedge clk_i);
    done = 1'b1;
    $display("requests sent %0d, results checked %0d, mismatches %0d", sent, got, errors);
    $display("covered fetch, new, delete, unpin, flush, eviction and unknown commands");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
hw/rtl/pbpm_pkg.sv
hw/rtl/pbpm_ram.sv
hw/rtl/pbpm_lru.sv
hw/rtl/page_buffer_pool_manager.sv
tb/tb.sv
